[sv/mrr_pkg.sv]
// ----------------------------------------------------------------------------
// mrr_pkg
// shared widths, types and request and response structs for the miller-rabin round
// ----------------------------------------------------------------------------
package mrr_pkg;

    localparam int NUM_BITS = 62;
    localparam int CNT_W    = $clog2(NUM_BITS + 1);

    typedef logic [NUM_BITS-1:0] t_word;
    typedef logic [CNT_W-1:0]    t_count;

    typedef struct packed {
        logic  start;
        t_word x;
        t_word y;
    } t_mul_req;

    typedef struct packed {
        logic  busy;
        logic  done;
        t_word product;
    } t_mul_rsp;

endpackage

[sv/miller_rabin_round.sv]
// ----------------------------------------------------------------------------
// miller_rabin_round
// one miller-rabin round on a candidate with a host-supplied witness
// ----------------------------------------------------------------------------
// result: small, even and out-of-range cases give the result in the cycle
//   after the request; a full round takes about (bits of d) squarings plus one
//   multiply per set bit of d plus up to s-1 squarings
// throughput: one request at a time, busy high until the result strobe;
//   the single shift-add multiplier handles one bit per cycle
// reset: synchronous active-low, returns to idle with no result pending
module miller_rabin_round (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  mrr_pkg::t_word i_candidate,
    input  mrr_pkg::t_word i_witness,
    output logic           o_done,
    output logic           o_probable_prime,
    output logic           o_decided_trivially,
    output logic           o_witness_out_of_range
);
    import mrr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_STRIP,
        S_ALIGN,
        S_POW_SQ,
        S_POW_SQ_W,
        S_POW_BIT,
        S_POW_MUL_W,
        S_FIN_CHK,
        S_LOOP,
        S_LOOP_W,
        S_LOOP_CHK
    } t_state;

    localparam t_word  ONE     = t_word'(1);
    localparam t_word  TWO     = t_word'(2);
    localparam t_word  THREE   = t_word'(3);
    localparam t_count FULL_CT = t_count'(NUM_BITS);

    t_state r_state, n_state;
    t_word  r_n, n_n;
    t_word  r_a, n_a;
    t_word  r_nm1, n_nm1;
    t_word  r_e, n_e;
    t_word  r_r, n_r;
    t_count r_s, n_s;
    t_count r_k, n_k;
    logic   r_mul_start, n_mul_start;
    t_word  r_mul_x, n_mul_x;
    t_word  r_mul_y, n_mul_y;
    logic   r_done, n_done;
    logic   r_prime, n_prime;
    logic   r_trivial, n_trivial;
    logic   r_oor, n_oor;

    logic     w_accept;
    logic     w_trivial;
    logic     w_small_prime;
    logic     w_oor;
    t_mul_req w_mul_req;
    t_mul_rsp w_mul_rsp;

    assign w_accept      = start && (r_state == S_IDLE);
    assign w_small_prime = (i_candidate == TWO) || (i_candidate == THREE);
    assign w_trivial     = (i_candidate[NUM_BITS-1:1] == '0) || !i_candidate[0]
                           || (i_candidate == THREE);
    assign w_oor         = (i_witness[NUM_BITS-1:1] == '0)
                           || (i_witness > (i_candidate - TWO));

    assign w_mul_req = '{start: r_mul_start, x: r_mul_x, y: r_mul_y};

    mrr_mulmod u_mulmod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_mul_req),
        .i_modulus (r_n),
        .o_rsp     (w_mul_rsp)
    );

    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_a         = r_a;
        n_nm1       = r_nm1;
        n_e         = r_e;
        n_r         = r_r;
        n_s         = r_s;
        n_k         = r_k;
        n_mul_start = 1'b0;
        n_mul_x     = r_mul_x;
        n_mul_y     = r_mul_y;
        n_done      = 1'b0;
        n_prime     = r_prime;
        n_trivial   = r_trivial;
        n_oor       = r_oor;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_n   = i_candidate;
                    n_a   = i_witness;
                    n_nm1 = i_candidate - ONE;
                    n_e   = i_candidate - ONE;
                    n_s   = '0;
                    priority if (w_trivial) begin
                        n_done    = 1'b1;
                        n_prime   = w_small_prime;
                        n_trivial = 1'b1;
                        n_oor     = 1'b0;
                    end else if (w_oor) begin
                        n_done    = 1'b1;
                        n_prime   = 1'b0;
                        n_trivial = 1'b0;
                        n_oor     = 1'b1;
                    end else begin
                        n_state = S_STRIP;
                    end
                end
            end
            S_STRIP: begin
                if (!r_e[0]) begin
                    n_e = r_e >> 1;
                    n_s = r_s + t_count'(1);
                end else begin
                    n_k     = FULL_CT;
                    n_state = S_ALIGN;
                end
            end
            S_ALIGN: begin
                // skip leading zeros of d; the top set bit leaves r = a
                n_e = r_e << 1;
                n_k = r_k - t_count'(1);
                if (r_e[NUM_BITS-1]) begin
                    n_r     = r_a;
                    n_state = S_POW_SQ;
                end
            end
            S_POW_SQ: begin
                if (r_k == '0) begin
                    n_state = S_FIN_CHK;
                end else begin
                    n_mul_start = 1'b1;
                    n_mul_x     = r_r;
                    n_mul_y     = r_r;
                    n_state     = S_POW_SQ_W;
                end
            end
            S_POW_SQ_W: begin
                if (w_mul_rsp.done) begin
                    n_r     = w_mul_rsp.product;
                    n_state = S_POW_BIT;
                end
            end
            S_POW_BIT: begin
                if (r_e[NUM_BITS-1]) begin
                    n_mul_start = 1'b1;
                    n_mul_x     = r_r;
                    n_mul_y     = r_a;
                    n_state     = S_POW_MUL_W;
                end else begin
                    n_e     = r_e << 1;
                    n_k     = r_k - t_count'(1);
                    n_state = S_POW_SQ;
                end
            end
            S_POW_MUL_W: begin
                if (w_mul_rsp.done) begin
                    n_r     = w_mul_rsp.product;
                    n_e     = r_e << 1;
                    n_k     = r_k - t_count'(1);
                    n_state = S_POW_SQ;
                end
            end
            S_FIN_CHK: begin
                if ((r_r == ONE) || (r_r == r_nm1)) begin
                    n_done    = 1'b1;
                    n_prime   = 1'b1;
                    n_trivial = 1'b0;
                    n_oor     = 1'b0;
                    n_state   = S_IDLE;
                end else begin
                    n_s     = r_s - t_count'(1);
                    n_state = S_LOOP;
                end
            end
            S_LOOP: begin
                if (r_s == '0) begin
                    n_done    = 1'b1;
                    n_prime   = 1'b0;
                    n_trivial = 1'b0;
                    n_oor     = 1'b0;
                    n_state   = S_IDLE;
                end else begin
                    n_mul_start = 1'b1;
                    n_mul_x     = r_r;
                    n_mul_y     = r_r;
                    n_state     = S_LOOP_W;
                end
            end
            S_LOOP_W: begin
                if (w_mul_rsp.done) begin
                    n_r     = w_mul_rsp.product;
                    n_s     = r_s - t_count'(1);
                    n_state = S_LOOP_CHK;
                end
            end
            S_LOOP_CHK: begin
                priority if (r_r == ONE) begin
                    n_done    = 1'b1;
                    n_prime   = 1'b0;
                    n_trivial = 1'b0;
                    n_oor     = 1'b0;
                    n_state   = S_IDLE;
                end else if (r_r == r_nm1) begin
                    n_done    = 1'b1;
                    n_prime   = 1'b1;
                    n_trivial = 1'b0;
                    n_oor     = 1'b0;
                    n_state   = S_IDLE;
                end else begin
                    n_state = S_LOOP;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mul_start <= 1'b0;
            r_done      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mul_start <= n_mul_start;
            r_done      <= n_done;
        end
        r_n       <= n_n;
        r_a       <= n_a;
        r_nm1     <= n_nm1;
        r_e       <= n_e;
        r_r       <= n_r;
        r_s       <= n_s;
        r_k       <= n_k;
        r_mul_x   <= n_mul_x;
        r_mul_y   <= n_mul_y;
        r_prime   <= n_prime;
        r_trivial <= n_trivial;
        r_oor     <= n_oor;
    end

    assign busy                   = (r_state != S_IDLE);
    assign o_done                 = r_done;
    assign o_probable_prime       = r_prime;
    assign o_decided_trivially    = r_trivial;
    assign o_witness_out_of_range = r_oor;

    // multiplier products arrive only while a wait state expects them
    a_mul_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_rsp.done |-> (r_state == S_POW_SQ_W || r_state == S_POW_MUL_W
                            || r_state == S_LOOP_W))
        else $error("multiplier result with no product pending");

    // a product request never lands on a busy multiplier
    a_mul_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mul_start |-> !w_mul_rsp.busy)
        else $error("multiplier request while busy");

    // small and even candidates answer on the next cycle
    a_trivial_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_trivial) |=> (o_done && o_decided_trivially && !busy))
        else $error("trivial verdict late");

    // the two flags never appear together
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_decided_trivially && o_witness_out_of_range))
        else $error("conflicting verdict flags");

endmodule

[sv/mrr_mulmod.sv]
// ----------------------------------------------------------------------------
// mrr_mulmod
// shift-add modular multiplier, one multiplier bit per cycle, lsb first
// ----------------------------------------------------------------------------
module mrr_mulmod (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mrr_pkg::t_mul_req i_req,
    input  mrr_pkg::t_word    i_modulus,
    output mrr_pkg::t_mul_rsp o_rsp
);
    import mrr_pkg::*;

    logic  r_busy, n_busy;
    logic  r_done, n_done;
    t_word r_acc, n_acc;
    t_word r_addend, n_addend;
    t_word r_mult, n_mult;

    // operands below the modulus, so one conditional subtract suffices
    function automatic t_word mod_add(t_word a, t_word b, t_word m);
        logic [NUM_BITS:0] sum;
        logic [NUM_BITS:0] diff;
        sum  = {1'b0, a} + {1'b0, b};
        diff = sum - {1'b0, m};
        return (sum >= {1'b0, m}) ? diff[NUM_BITS-1:0] : sum[NUM_BITS-1:0];
    endfunction

    always_comb begin
        n_busy   = r_busy;
        n_done   = 1'b0;
        n_acc    = r_acc;
        n_addend = r_addend;
        n_mult   = r_mult;
        if (r_busy) begin
            if (r_mult == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                if (r_mult[0]) begin
                    n_acc = mod_add(r_acc, r_addend, i_modulus);
                end
                n_addend = mod_add(r_addend, r_addend, i_modulus);
                n_mult   = r_mult >> 1;
            end
        end else if (i_req.start) begin
            n_busy   = 1'b1;
            n_acc    = '0;
            n_addend = i_req.x;
            n_mult   = i_req.y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_acc    <= n_acc;
        r_addend <= n_addend;
        r_mult   <= n_mult;
    end

    assign o_rsp = '{busy: r_busy, done: r_done, product: r_acc};

endmodule

[verif/mrr_verdict_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mrr_verdict_checker
// watches the request and result ports of the miller-rabin round, works out
// the verdict of every accepted request and compares it with the result
// ----------------------------------------------------------------------------
module mrr_verdict_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_busy,
    input  mrr_pkg::t_word i_candidate,
    input  mrr_pkg::t_word i_witness,
    input  logic           i_done,
    input  logic           i_probable_prime,
    input  logic           i_decided_trivially,
    input  logic           i_witness_out_of_range,
    output int             o_pending,
    output int             o_fail_count
);
    import mrr_pkg::*;

    typedef struct packed {
        logic probable_prime;
        logic decided_trivially;
        logic witness_out_of_range;
    } t_verdict;

    t_verdict verdict_q[$];
    int       fails = 0;

    function automatic bit [63:0] mod_mul(bit [63:0] x, bit [63:0] y, bit [63:0] n);
        bit [63:0] acc;
        bit [63:0] addend;
        acc    = 64'd0;
        addend = x % n;
        while (y != 64'd0) begin
            if (y[0]) begin
                acc = (acc + addend) % n;
            end
            addend = (addend << 1) % n;
            y      = y >> 1;
        end
        return acc;
    endfunction

    function automatic bit [63:0] mod_pow(bit [63:0] base, bit [63:0] e, bit [63:0] n);
        bit [63:0] r;
        r = 64'd1 % n;
        for (int b = 63; b >= 0; b--) begin
            r = mod_mul(r, r, n);
            if (e[b]) begin
                r = mod_mul(r, base, n);
            end
        end
        return r;
    endfunction

    function automatic t_verdict round_verdict(t_word cand, t_word wit);
        bit [63:0] n;
        bit [63:0] a;
        bit [63:0] d;
        bit [63:0] x;
        int        s;
        t_verdict  v;
        v = '0;
        n = 64'(cand);
        a = 64'(wit);
        if (n <= 64'd4 || !n[0]) begin
            v.probable_prime    = (n == 64'd2 || n == 64'd3);
            v.decided_trivially = 1'b1;
            return v;
        end
        if (a < 64'd2 || a > n - 64'd2) begin
            v.witness_out_of_range = 1'b1;
            return v;
        end
        d = n - 64'd1;
        s = 0;
        while (!d[0]) begin
            d = d >> 1;
            s++;
        end
        x = mod_pow(a, d, n);
        if (x == 64'd1 || x == n - 64'd1) begin
            v.probable_prime = 1'b1;
        end else begin
            for (int i = 1; i < s; i++) begin
                x = mod_mul(x, x, n);
                if (x == 64'd1) begin
                    break;
                end
                if (x == n - 64'd1) begin
                    v.probable_prime = 1'b1;
                    break;
                end
            end
        end
        return v;
    endfunction

    always @(posedge i_clk) begin
        t_verdict want;
        if (!i_rst_n) begin
            verdict_q.delete();
        end else begin
            if (i_done) begin
                if (verdict_q.size() == 0) begin
                    $error("result strobe with no request outstanding");
                    fails++;
                end else begin
                    want = verdict_q.pop_front();
                    if (i_probable_prime !== want.probable_prime) begin
                        $error("probable_prime: expected %0d, actual %0d",
                               want.probable_prime, i_probable_prime);
                        fails++;
                    end
                    if (i_decided_trivially !== want.decided_trivially) begin
                        $error("decided_trivially: expected %0d, actual %0d",
                               want.decided_trivially, i_decided_trivially);
                        fails++;
                    end
                    if (i_witness_out_of_range !== want.witness_out_of_range) begin
                        $error("witness_out_of_range: expected %0d, actual %0d",
                               want.witness_out_of_range, i_witness_out_of_range);
                        fails++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                verdict_q = {verdict_q, round_verdict(i_candidate, i_witness)};
            end
        end
        o_pending    <= verdict_q.size();
        o_fail_count <= fails;
    end

endmodule

[verif/miller_rabin_round_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// miller_rabin_round_test
// drives directed and random candidate/witness requests into the round with
// random gaps, and reports the verdict of the checker beside it
// ----------------------------------------------------------------------------
module miller_rabin_round_test;

    import mrr_pkg::*;

    localparam int RANDOM_REQUESTS = 100;
    localparam int WATCHDOG_LIMIT  = 100_000;
    localparam int DRAIN_CYCLES    = 50;

    logic  clk                  = 1'b0;
    logic  rst_n                = 1'b0;
    logic  start                = 1'b0;
    t_word candidate            = '0;
    t_word witness              = '0;
    logic  busy;
    logic  done;
    logic  probable_prime;
    logic  decided_trivially;
    logic  witness_out_of_range;
    int    pending;
    int    fail_count;
    int    idle_cycles          = 0;
    int    burst_left           = 0;

    t_word notable_odd [8] = '{
        62'd2305843009213693951, 62'd4611686018427387847, 62'd1000000007,
        62'd998244353, 62'd4294967291, 62'd3215031751, 62'd2047, 62'd1373653
    };

    always #10 clk = ~clk;

    miller_rabin_round dut (
        .i_clk                  (clk),
        .i_rst_n                (rst_n),
        .start                  (start),
        .busy                   (busy),
        .i_candidate            (candidate),
        .i_witness              (witness),
        .o_done                 (done),
        .o_probable_prime       (probable_prime),
        .o_decided_trivially    (decided_trivially),
        .o_witness_out_of_range (witness_out_of_range)
    );

    mrr_verdict_checker verdict_chk (
        .i_clk                  (clk),
        .i_rst_n                (rst_n),
        .i_start                (start),
        .i_busy                 (busy),
        .i_candidate            (candidate),
        .i_witness              (witness),
        .i_done                 (done),
        .i_probable_prime       (probable_prime),
        .i_decided_trivially    (decided_trivially),
        .i_witness_out_of_range (witness_out_of_range),
        .o_pending              (pending),
        .o_fail_count           (fail_count)
    );

    always @(posedge clk) begin
        if ((start && !busy) || done) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic bit [63:0] rand_word(int bits);
        bit [63:0] v;
        v = {$urandom, $urandom};
        if (bits < 64) begin
            v = v & ((64'd1 << bits) - 64'd1);
        end
        return v;
    endfunction

    task automatic send_request(t_word c, t_word w);
        int gap;
        int roll;
        candidate <= c;
        witness   <= w;
        start     <= 1'b1;
        do @(negedge clk); while (busy);
        @(posedge clk);
        if (burst_left > 0) begin
            burst_left--;
            gap = 0;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                burst_left = $urandom_range(4, 12);
                gap        = 0;
            end else if (roll < 50) begin
                gap = 0;
            end else if (roll < 90) begin
                gap = $urandom_range(1, 4);
            end else begin
                gap = $urandom_range(20, 300);
            end
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    initial begin
        bit [63:0] n;
        bit [63:0] w;
        int        sel;
        int        width;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // small and even candidates
        send_request(62'd0, 62'd0);
        send_request(62'd1, '1);
        send_request(62'd2, 62'd0);
        send_request(62'd3, 62'd1);
        send_request(62'd4, 62'd2);
        send_request(62'd6, 62'd3);
        send_request(62'd4611686018427387902, '1);
        // witness at and beyond the range edges
        send_request(62'd5, 62'd0);
        send_request(62'd5, 62'd1);
        send_request(62'd5, 62'd2);
        send_request(62'd5, 62'd3);
        send_request(62'd5, 62'd4);
        send_request(62'd7, '1);
        send_request(62'd4611686018427387903, '1);
        send_request(62'd4611686018427387903, 62'd4611686018427387901);
        // full rounds
        send_request(62'd9, 62'd2);
        send_request(62'd561, 62'd2);
        send_request(62'd2047, 62'd2);
        send_request(62'd1373653, 62'd3);
        send_request(62'd3215031751, 62'd2);
        send_request(62'd2305843009213693951, 62'd3);
        send_request(62'd4611686018427387847, 62'd2);
        send_request(62'd4611686018427387847, 62'd4611686018427387845);

        for (int k = 0; k < RANDOM_REQUESTS; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < 12) begin
                n = 64'(notable_odd[$urandom_range(0, 7)]);
                w = 64'd2 + rand_word(64) % (n - 64'd3);
            end else if (sel < 75) begin
                sel = $urandom_range(0, 99);
                width = (sel < 70) ? $urandom_range(3, 16) :
                        (sel < 90) ? $urandom_range(17, 40) : NUM_BITS;
                n = rand_word(width) | 64'd1 | (64'd1 << (width - 1));
                w = 64'd2 + rand_word(64) % (n - 64'd3);
            end else if (sel < 85) begin
                n = rand_word(NUM_BITS);
                w = rand_word(NUM_BITS);
            end else if (sel < 92) begin
                n = 64'($urandom_range(0, 12));
                w = rand_word($urandom_range(1, NUM_BITS));
            end else begin
                n = rand_word($urandom_range(3, NUM_BITS)) | 64'd5;
                case ($urandom_range(0, 3))
                    0: w = 64'd0;
                    1: w = 64'd1;
                    2: w = n - 64'd1;
                    default: w = rand_word(NUM_BITS) | n;
                endcase
            end
            send_request(t_word'(n), t_word'(w));
        end

        start <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[files.f]
sv/mrr_pkg.sv
sv/mrr_mulmod.sv
sv/miller_rabin_round.sv
verif/mrr_verdict_checker.sv
verif/miller_rabin_round_test.sv
